>>> sv/ffba_pkg.sv
`default_nettype none
package ffba_pkg;

	// Default sizing of the extent table and of block indexes.
	localparam int MAX_EXTENTS_DEF      = 64;
	localparam int BLOCK_INDEX_BITS_DEF = 16;

	// Fixed widths of the port fields.
	localparam int MODE_W   = 2;
	localparam int FIELD_W  = 16;
	localparam int STATUS_W = 3;

	// Heap end after reset.
	localparam logic [FIELD_W-1:0] HEAP_END_RESET = 16'd4096;

	// Request codes.
	localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FREE    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REALLOC = 2'd2;

	// Result codes.
	localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ZERO_COUNT = 3'd4;

endpackage
`default_nettype wire

>>> sv/ffba_ram.sv
`default_nettype none
module ffba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one read port with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> sv/first_fit_block_allocator_unit.sv
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+----------------------------------------
// request  | in        | in_valid/in_ready  | mode, block_count, handle
// result   | out       | out_valid/out_ready| status, block_index, moved, old_index
// config   | in        | cfg_wr_en          | cfg_wr_data (heap end block)
//
// The extent table sits in a RAM with one write port, one read port and registered
// read, so a first-fit scan, a handle scan and every entry shifted on insert or
// remove read each table entry in one state and use it in the next.
// A reallocate that relocates does a handle scan, a fit scan, an insert and a
// remove, so it is the slowest request.
// Reset clears the table to the head extent alone; no clearing pass is needed.
// The block takes no new request while one is in work or waits to hand over its result.
`default_nettype none
module first_fit_block_allocator_unit #(
	parameter int MAX_EXTENTS      = ffba_pkg::MAX_EXTENTS_DEF,
	parameter int BLOCK_INDEX_BITS = ffba_pkg::BLOCK_INDEX_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [ffba_pkg::FIELD_W-1:0]   cfg_wr_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [ffba_pkg::MODE_W-1:0]    mode,
	input  wire logic [ffba_pkg::FIELD_W-1:0]   block_count,
	input  wire logic [ffba_pkg::FIELD_W-1:0]   handle,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic      [ffba_pkg::STATUS_W-1:0]  status,
	output logic      [ffba_pkg::FIELD_W-1:0]   block_index,
	output logic                                moved,
	output logic      [ffba_pkg::FIELD_W-1:0]   old_index
);
	import ffba_pkg::*;

	localparam int W  = BLOCK_INDEX_BITS;
	localparam int AW = $clog2(MAX_EXTENTS);
	localparam int CW = $clog2(MAX_EXTENTS + 1);
	localparam int EW = ((W > FIELD_W) ? W : FIELD_W) + 2;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_FS_RD = 4'd1;
	localparam logic [3:0] S_FS_EV = 4'd2;
	localparam logic [3:0] S_HS_RD = 4'd3;
	localparam logic [3:0] S_HS_EV = 4'd4;
	localparam logic [3:0] S_GP_RD = 4'd5;
	localparam logic [3:0] S_GP_EV = 4'd6;
	localparam logic [3:0] S_GROW  = 4'd7;
	localparam logic [3:0] S_SU_RD = 4'd8;
	localparam logic [3:0] S_SU_EV = 4'd9;
	localparam logic [3:0] S_SD_RD = 4'd10;
	localparam logic [3:0] S_SD_EV = 4'd11;
	localparam logic [3:0] S_DONE  = 4'd12;

	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_EXTENTS);
	localparam logic [EW-1:0] CAP     = EW'(1) << W;

	logic [3:0]          state_q;
	logic [FIELD_W-1:0]  heap_end_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       j_q;
	logic [CW-1:0]       pos_q;
	logic [CW-1:0]       ipos_q;
	logic [EW-1:0]       prev_end_q;
	logic [EW-1:0]       need_q;
	logic [W-1:0]        where_q;
	logic [W-1:0]        len_q;
	logic                reloc_q;
	logic [MODE_W-1:0]   mode_q;
	logic [FIELD_W-1:0]  h_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [FIELD_W-1:0]  res_idx_q;
	logic                res_moved_q;
	logic [FIELD_W-1:0]  res_old_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [FIELD_W-1:0]  out_idx_q;
	logic                out_moved_q;
	logic [FIELD_W-1:0]  out_old_q;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [2*W-1:0]      ram_wdata;
	logic [AW-1:0]       ram_raddr;
	logic [2*W-1:0]      ram_rdata;
	logic [W-1:0]        rd_start;
	logic [W-1:0]        rd_len;
	logic [EW-1:0]       rd_end;
	logic [EW-1:0]       limit;
	logic [EW-1:0]       fit_to;
	logic                fit_ok;
	logic [CW-1:0]       j_dec;
	logic [CW-1:0]       j_inc;
	logic                in_xfer;

	assign in_ready  = (state_q == S_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign rd_start  = ram_rdata[2*W-1:W];
	assign rd_len    = ram_rdata[W-1:0];
	assign rd_end    = EW'(rd_start) + EW'(rd_len);
	assign j_dec     = j_q - CW'(1);
	assign j_inc     = j_q + CW'(1);
	assign limit     = (EW'(heap_end_q) < CAP) ? EW'(heap_end_q) : CAP;

	// Shared gap test: does the gap from the previous end up to fit_to hold need_q blocks?
	assign fit_to = ((state_q == S_FS_RD) || (state_q == S_GP_RD)) ? limit : EW'(rd_start);
	assign fit_ok = (fit_to >= prev_end_q + need_q);

	// Table RAM port control.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = j_q[AW-1:0];
		ram_wdata = ram_rdata;
		ram_raddr = j_q[AW-1:0];
		case (state_q)
			S_SU_RD: begin
				ram_raddr = j_dec[AW-1:0];
				ram_we    = (j_q == ipos_q);
				ram_waddr = ipos_q[AW-1:0];
				ram_wdata = {where_q, W'(need_q)};
			end
			S_SU_EV: begin
				ram_we = 1'b1;
			end
			S_SD_EV: begin
				ram_we    = 1'b1;
				ram_waddr = j_dec[AW-1:0];
			end
			S_GROW: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q[AW-1:0];
				ram_wdata = {W'(h_q), W'(EW'(len_q) + need_q)};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	ffba_ram #(
		.WIDTH(2 * W),
		.DEPTH(MAX_EXTENTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_end_q <= HEAP_END_RESET;
		end else if (cfg_wr_en) begin
			heap_end_q <= cfg_wr_data;
		end
	end

	// Request sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= CW'(1);
			out_valid_q <= 1'b0;
		end else begin
			// The done state loads the next result itself, so only clear outside it.
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						mode_q       <= mode;
						h_q          <= handle;
						need_q       <= EW'(block_count);
						prev_end_q   <= EW'(1);
						j_q          <= CW'(1);
						reloc_q      <= 1'b0;
						res_status_q <= ST_OK;
						res_idx_q    <= '0;
						res_moved_q  <= 1'b0;
						res_old_q    <= '0;
						if (mode == MODE_ALLOC) begin
							if (block_count == '0) begin
								res_status_q <= ST_ZERO_COUNT;
								state_q      <= S_DONE;
							end else if (count_q >= CNT_MAX) begin
								res_status_q <= ST_TABLE_FULL;
								state_q      <= S_DONE;
							end else begin
								state_q <= S_FS_RD;
							end
						end else if (mode == MODE_FREE) begin
							state_q <= S_HS_RD;
						end else if (mode == MODE_REALLOC) begin
							if (block_count == '0) begin
								res_status_q <= ST_ZERO_COUNT;
								state_q      <= S_DONE;
							end else begin
								state_q <= S_HS_RD;
							end
						end else begin
							res_status_q <= ST_NOT_FOUND;
							state_q      <= S_DONE;
						end
					end
				end
				S_FS_RD: begin
					// Past the last extent the gap runs to the heap end, or to the index range if smaller.
					if (j_q == count_q) begin
						if (fit_ok) begin
							ipos_q  <= j_q;
							where_q <= W'(prev_end_q);
							state_q <= S_SU_RD;
						end else begin
							res_status_q <= ST_NO_SPACE;
							state_q      <= S_DONE;
						end
					end else begin
						state_q <= S_FS_EV;
					end
				end
				S_FS_EV: begin
					if (fit_ok) begin
						ipos_q  <= j_q;
						where_q <= W'(prev_end_q);
						j_q     <= count_q;
						state_q <= S_SU_RD;
					end else begin
						prev_end_q <= rd_end;
						j_q        <= j_inc;
						state_q    <= S_FS_RD;
					end
				end
				S_HS_RD: begin
					if (j_q == count_q) begin
						res_status_q <= ST_NOT_FOUND;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_HS_EV;
					end
				end
				S_HS_EV: begin
					if (EW'(rd_start) == EW'(h_q)) begin
						pos_q      <= j_q;
						len_q      <= rd_len;
						prev_end_q <= rd_end;
						j_q        <= j_inc;
						state_q    <= (mode_q == MODE_FREE) ? S_SD_RD : S_GP_RD;
					end else begin
						j_q     <= j_inc;
						state_q <= S_HS_RD;
					end
				end
				S_GP_RD, S_GP_EV: begin
					if ((state_q == S_GP_RD) && (j_q != count_q)) begin
						state_q <= S_GP_EV;
					end else if (fit_ok) begin
						state_q <= S_GROW;
					end else if (count_q >= CNT_MAX) begin
						res_status_q <= ST_TABLE_FULL;
						state_q      <= S_DONE;
					end else begin
						// Relocate: look for room for the whole grown extent.
						need_q     <= EW'(len_q) + need_q;
						prev_end_q <= EW'(1);
						j_q        <= CW'(1);
						reloc_q    <= 1'b1;
						state_q    <= S_FS_RD;
					end
				end
				S_GROW: begin
					res_idx_q <= h_q;
					state_q   <= S_DONE;
				end
				S_SU_RD: begin
					// Move entries up one place until the insert slot is open.
					if (j_q == ipos_q) begin
						count_q <= count_q + CW'(1);
						if (reloc_q) begin
							pos_q   <= (ipos_q <= pos_q) ? pos_q + CW'(1) : pos_q;
							j_q     <= ((ipos_q <= pos_q) ? pos_q + CW'(1) : pos_q) + CW'(1);
							state_q <= S_SD_RD;
						end else begin
							res_idx_q <= FIELD_W'(where_q);
							state_q   <= S_DONE;
						end
					end else begin
						state_q <= S_SU_EV;
					end
				end
				S_SU_EV: begin
					j_q     <= j_dec;
					state_q <= S_SU_RD;
				end
				S_SD_RD: begin
					// Close the hole left by the removed entry.
					if (j_q == count_q) begin
						count_q <= count_q - CW'(1);
						if (reloc_q) begin
							res_idx_q   <= FIELD_W'(where_q);
							res_moved_q <= 1'b1;
							res_old_q   <= h_q;
						end else begin
							res_idx_q <= h_q;
						end
						state_q <= S_DONE;
					end else begin
						state_q <= S_SD_EV;
					end
				end
				S_SD_EV: begin
					j_q     <= j_inc;
					state_q <= S_SD_RD;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_idx_q    <= res_idx_q;
						out_moved_q  <= res_moved_q;
						out_old_q    <= res_old_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign block_index = out_idx_q;
	assign moved       = out_moved_q;
	assign old_index   = out_old_q;

	// The table always holds the head extent and never more than its depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CW'(1)) && (count_q <= CNT_MAX))
		else $error("extent count out of range");

	// The head extent lives outside the RAM and is never overwritten.
	a_no_head_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (ram_waddr != '0))
		else $error("write to head entry");

	// Completing an insert adds exactly one entry.
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SU_RD) && (j_q == ipos_q)) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow the table");

	// A relocation is only ever reported with a good status.
	a_moved_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_moved_q) |-> (out_status_q == ST_OK))
		else $error("moved flag on failed request");

endmodule
`default_nettype wire

>>> dv/first_fit_block_allocator_unit_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module first_fit_block_allocator_unit_tb;
	import ffba_pkg::*;

	localparam int MAX_EXT = MAX_EXTENTS_DEF;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [FIELD_W-1:0] count;
		logic [FIELD_W-1:0] hnd;
	} request_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FIELD_W-1:0]  index;
		logic                moved;
		logic [FIELD_W-1:0]  old_index;
	} answer_t;

	localparam logic [MODE_W-1:0] MODE_UNDEF = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [FIELD_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [MODE_W-1:0] mode = '0;
	logic [FIELD_W-1:0] block_count = '0;
	logic [FIELD_W-1:0] handle = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [FIELD_W-1:0] block_index;
	logic moved;
	logic [FIELD_W-1:0] old_index;

	first_fit_block_allocator_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .block_count(block_count), .handle(handle),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .block_index(block_index),
		.moved(moved), .old_index(old_index)
	);

	// Shadow of the extent table and heap end.
	int unsigned ext_start [MAX_EXT];
	int unsigned ext_len [MAX_EXT];
	int ext_count;
	int unsigned heap_end;

	request_t pending_requests[$];
	answer_t expected_answers[$];
	int failures = 0;
	int cycles = 0;

	// Idling controls.
	bit calm = 1'b0;
	bit want_hold = 1'b0;
	bit hold_done = 1'b0;
	int hold_off = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int unsigned gap_after(int i);
		int unsigned e;
		int unsigned lim;
		e = ext_start[i] + ext_len[i];
		lim = heap_end;
		if (i + 1 < ext_count)
			lim = ext_start[i + 1];
		return (lim > e) ? lim - e : 0;
	endfunction

	function automatic int first_fit(int unsigned need);
		for (int i = 0; i < ext_count; i++) begin
			if (gap_after(i) >= need)
				return i + 1;
		end
		return -1;
	endfunction

	function automatic int lookup_handle(int unsigned h);
		for (int i = 1; i < ext_count; i++) begin
			if (ext_start[i] == h)
				return i;
		end
		return -1;
	endfunction

	function automatic void insert_extent(int p, int unsigned s, int unsigned l);
		for (int i = ext_count; i > p; i--) begin
			ext_start[i] = ext_start[i - 1];
			ext_len[i] = ext_len[i - 1];
		end
		ext_start[p] = s;
		ext_len[p] = l;
		ext_count++;
	endfunction

	function automatic void remove_extent(int p);
		for (int i = p; i < ext_count - 1; i++) begin
			ext_start[i] = ext_start[i + 1];
			ext_len[i] = ext_len[i + 1];
		end
		ext_count--;
	endfunction

	// Applies one request to the shadow table and returns the expected answer.
	function automatic answer_t allocate_step(request_t r);
		answer_t a;
		int p;
		int ip;
		int unsigned where;
		int unsigned need;
		a = '0;
		case (r.mode)
			MODE_ALLOC: begin
				ip = first_fit(r.count);
				if (r.count == 0)
					a.status = ST_ZERO_COUNT;
				else if (ext_count >= MAX_EXT)
					a.status = ST_TABLE_FULL;
				else if (ip < 0)
					a.status = ST_NO_SPACE;
				else begin
					where = ext_start[ip - 1] + ext_len[ip - 1];
					insert_extent(ip, where, r.count);
					a.index = FIELD_W'(where);
				end
			end
			MODE_FREE: begin
				p = lookup_handle(r.hnd);
				if (p < 0)
					a.status = ST_NOT_FOUND;
				else begin
					remove_extent(p);
					a.index = r.hnd;
				end
			end
			MODE_REALLOC: begin
				p = lookup_handle(r.hnd);
				if (r.count == 0)
					a.status = ST_ZERO_COUNT;
				else if (p < 0)
					a.status = ST_NOT_FOUND;
				else if (gap_after(p) >= r.count) begin
					ext_len[p] += r.count;
					a.index = r.hnd;
				end else if (ext_count >= MAX_EXT)
					a.status = ST_TABLE_FULL;
				else begin
					need = ext_len[p] + r.count;
					ip = first_fit(need);
					if (ip < 0)
						a.status = ST_NO_SPACE;
					else begin
						where = ext_start[ip - 1] + ext_len[ip - 1];
						insert_extent(ip, where, need);
						if (ip <= p)
							p++;
						remove_extent(p);
						a.index = FIELD_W'(where);
						a.moved = 1'b1;
						a.old_index = r.hnd;
					end
				end
			end
			default: a.status = ST_NOT_FOUND;
		endcase
		return a;
	endfunction

	// Driver: takes the next pending request once the previous transfer is done.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_ready) begin
				if (pending_requests.size() != 0 && (calm || $urandom_range(99) >= 37)) begin
					request_t r;
					r = pending_requests.pop_front();
					in_valid <= 1'b1;
					mode <= r.mode;
					block_count <= r.count;
					handle <= r.hnd;
					expected_answers.push_back(allocate_step(r));
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// Receiver readiness, with one long hold-off counted here.
	always @(posedge clk) begin
		if (want_hold && !hold_done) begin
			hold_done <= 1'b1;
			hold_off <= 300;
			out_ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= calm || ($urandom_range(99) >= 37);
	end

	// Monitor: compares each result transfer with the oldest expectation.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (out_valid && out_ready) begin
			if (expected_answers.size() == 0) begin
				$error("result transfer with no expectation");
				failures = failures + 1;
			end else begin
				answer_t e;
				e = expected_answers.pop_front();
				if (status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, status);
					failures = failures + 1;
				end
				if (block_index !== e.index) begin
					$error("block_index: expected %0d, got %0d", e.index, block_index);
					failures = failures + 1;
				end
				if (moved !== e.moved) begin
					$error("moved: expected %0d, got %0d", e.moved, moved);
					failures = failures + 1;
				end
				if (old_index !== e.old_index) begin
					$error("old_index: expected %0d, got %0d", e.old_index, old_index);
					failures = failures + 1;
				end
			end
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Picks a handle, mostly a live extent start.
	function automatic logic [FIELD_W-1:0] pick_handle();
		if (ext_count > 1 && $urandom_range(9) < 8)
			return FIELD_W'(ext_start[$urandom_range(ext_count - 1, 1)]);
		if ($urandom_range(1))
			return FIELD_W'($urandom);
		return FIELD_W'($urandom_range(2, 0));
	endfunction

	function automatic logic [FIELD_W-1:0] pick_count();
		case ($urandom_range(19))
			0: return '0;
			1: return FIELD_W'($urandom);
			2, 3: return FIELD_W'($urandom_range(400, 1));
			default: return FIELD_W'($urandom_range(40, 1));
		endcase
	endfunction

	task automatic queue_request(logic [MODE_W-1:0] m, logic [FIELD_W-1:0] c,
			logic [FIELD_W-1:0] h);
		request_t r;
		r.mode = m;
		r.count = c;
		r.hnd = h;
		pending_requests.push_back(r);
	endtask

	// Waits for every queued request to be answered, then lets the block settle.
	task automatic drain();
		while (pending_requests.size() != 0 || expected_answers.size() != 0 || in_valid)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_heap_end(logic [FIELD_W-1:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		heap_end = v;
	endtask

	// Shadow table lives in the driver's process, so random requests are generated against
	// the table after the requests already sent, not after those still queued.
	task automatic random_phase(int n);
		for (int k = 0; k < n; k++) begin
			int sel;
			sel = $urandom_range(99);
			if (sel < 45)
				queue_request(MODE_ALLOC, pick_count(), FIELD_W'($urandom));
			else if (sel < 75)
				queue_request(MODE_FREE, FIELD_W'($urandom), pick_handle());
			else if (sel < 97)
				queue_request(MODE_REALLOC, pick_count(), pick_handle());
			else
				queue_request(MODE_UNDEF, FIELD_W'($urandom), FIELD_W'($urandom));
			// Keep the queue short so handles track the live table.
			while (pending_requests.size() > 2)
				@(posedge clk);
		end
	endtask

	initial begin
		ext_start[0] = 0;
		ext_len[0] = 1;
		ext_count = 1;
		heap_end = HEAP_END_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, every operation and the special cases.
		queue_request(MODE_ALLOC, 0, 0);
		queue_request(MODE_REALLOC, 0, 1);
		queue_request(MODE_FREE, 0, 0);
		queue_request(MODE_FREE, 0, 16'hFFFF);
		queue_request(MODE_UNDEF, 16'hFFFF, 16'hFFFF);
		queue_request(MODE_ALLOC, 16'hFFFF, 0);
		queue_request(MODE_ALLOC, 10, 0);
		queue_request(MODE_ALLOC, 20, 0);
		queue_request(MODE_REALLOC, 5, 1);
		queue_request(MODE_ALLOC, 4095, 0);
		queue_request(MODE_FREE, 0, 1);
		queue_request(MODE_ALLOC, 3, 0);
		queue_request(MODE_REALLOC, 4000, 16'd11);
		queue_request(MODE_REALLOC, 1, 16'h0000);
		queue_request(MODE_ALLOC, 4096 - 70, 0);
		drain();

		// Fill the table to its limit with single blocks on a large heap.
		write_heap_end(16'hFFFF);
		repeat (MAX_EXT + 1)
			queue_request(MODE_ALLOC, 1, 0);
		drain();
		queue_request(MODE_REALLOC, 16'hFFFF, 16'd70);
		queue_request(MODE_FREE, 0, 16'd3);
		queue_request(MODE_ALLOC, 1, 0);
		drain();

		// Long receiver hold-off while requests keep coming.
		want_hold = 1'b1;
		random_phase(10);
		drain();

		// Shrunk heap end below the last extent, then the smallest heap.
		write_heap_end(16'd40);
		random_phase(200);
		drain();
		write_heap_end(16'd2);
		random_phase(100);
		drain();
		write_heap_end(16'd1000);
		random_phase(500);
		drain();
		calm = 1'b1;
		random_phase(200);
		drain();
		calm = 1'b0;
		write_heap_end(HEAP_END_RESET);
		random_phase(750);
		drain();
		repeat (200) @(posedge clk);

		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire
